[rtl/rn48_pkg.sv]
// ----------------------------------------------------------------------------
// rn48_pkg
// Shared types, constants and helper functions for the node48 child table.
// ----------------------------------------------------------------------------
package rn48_pkg;

    localparam int SLOTS      = 48;
    localparam int KEYS       = 256;
    localparam int SCAN_CHUNK = 32;
    localparam int CHUNKS     = KEYS / SCAN_CHUNK;
    localparam int SLOT_W     = 6;
    localparam int CHUNK_W    = $clog2(CHUNKS);
    localparam int CIDX_W     = $clog2(SCAN_CHUNK);
    localparam int PC_W       = $clog2(SCAN_CHUNK + 1);
    localparam logic [5:0] UNDERFULL_RST = 6'd12;

    localparam logic [2:0] OP_INSERT = 3'd0;
    localparam logic [2:0] OP_REMOVE = 3'd1;
    localparam logic [2:0] OP_CHANGE = 3'd2;
    localparam logic [2:0] OP_LOOKUP = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;
    localparam logic [2:0] OP_SEEK   = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_MISS = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef enum logic [2:0] {
        CMD_INSERT,
        CMD_REMOVE,
        CMD_CHANGE,
        CMD_LOOKUP,
        CMD_SELECT,
        CMD_SEEK,
        CMD_BAD
    } t_cmd;

    typedef struct packed {
        logic [2:0]  operation;
        logic [7:0]  key_byte;
        logic [63:0] child_value;
        logic [5:0]  wanted_rank;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] found_child;
        logic [7:0]  found_key;
        logic [5:0]  found_rank;
        logic [5:0]  occupancy;
        logic        is_full;
        logic        is_underfull;
    } t_out;

    typedef struct packed {
        t_cmd        cmd;
        logic [7:0]  key;
        logic [63:0] value;
        logic [5:0]  rank;
    } t_req;

    function automatic logic [PC_W-1:0] popcount_chunk(input logic [SCAN_CHUNK-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int i = 0; i < SCAN_CHUNK; i++) begin
            n = n + PC_W'(v[i]);
        end
        return n;
    endfunction

    function automatic logic [CIDX_W-1:0] first_set_chunk(input logic [SCAN_CHUNK-1:0] v);
        logic [CIDX_W-1:0] idx;
        idx = '0;
        for (int i = SCAN_CHUNK - 1; i >= 0; i--) begin
            if (v[i]) begin
                idx = CIDX_W'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [SLOT_W-1:0] first_free(input logic [SLOTS-1:0] used);
        logic [SLOT_W-1:0] idx;
        idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!used[i]) begin
                idx = SLOT_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

[rtl/rn48_front.sv]
// ----------------------------------------------------------------------------
// rn48_front
// Accepts input beats, decodes the operation and queues requests (2 deep).
// ----------------------------------------------------------------------------
module rn48_front import rn48_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_stall,
    input  t_in  i_in,
    output logic o_q_valid,
    output t_req o_q_req,
    input  logic i_q_pop
);

    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    t_req       w_req;
    logic       w_push;

    always_comb begin
        w_req.key   = i_in.key_byte;
        w_req.value = i_in.child_value;
        w_req.rank  = i_in.wanted_rank;
        unique case (i_in.operation)
            OP_INSERT: w_req.cmd = CMD_INSERT;
            OP_REMOVE: w_req.cmd = CMD_REMOVE;
            OP_CHANGE: w_req.cmd = CMD_CHANGE;
            OP_LOOKUP: w_req.cmd = CMD_LOOKUP;
            OP_SELECT: w_req.cmd = CMD_SELECT;
            OP_SEEK:   w_req.cmd = CMD_SEEK;
            default:   w_req.cmd = CMD_BAD;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_cnt != 2'd0);
    assign o_q_req    = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_req;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (i_q_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(i_q_pop);
        end
    end

endmodule

[rtl/rn48_back.sv]
// ----------------------------------------------------------------------------
// rn48_back
// Executes requests against the key map and slot store; holds the result.
// ----------------------------------------------------------------------------
module rn48_back import rn48_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata,
    input  logic       i_q_valid,
    input  t_req       i_q_req,
    output logic       o_q_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out
);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_RDMAP, S_RDVAL, S_EXEC} t_state;

    t_state             r_state;
    t_req               r_req;
    logic [7:0]         r_key;
    logic [5:0]         r_frank;
    logic [5:0]         r_left;
    logic [CHUNK_W-1:0] r_chunk;
    logic               r_miss;
    logic [KEYS-1:0]    r_valid;
    logic [SLOTS-1:0]   r_used;
    logic [5:0]         r_count;
    logic [5:0]         r_under;
    logic               r_out_valid;
    t_out               r_out;

    logic [SLOT_W-1:0]  r_map [KEYS];
    logic [63:0]        r_vals [SLOTS];
    logic [SLOT_W-1:0]  r_map_q;
    logic [63:0]        r_val_q;

    logic [SCAN_CHUNK-1:0] w_ch, w_ge, w_hit, w_sel;
    logic [PC_W-1:0]       w_pc_all, w_pc_lt;
    logic                  w_go, w_present;
    logic [SLOT_W-1:0]     w_pos;
    logic [5:0]            n_count;
    t_out                  n_out;
    logic                  w_map_we, w_val_we;
    logic [63:0]           w_val_wd;
    logic [SLOT_W-1:0]     w_val_wa;

    assign w_ch      = r_valid[r_chunk*SCAN_CHUNK +: SCAN_CHUNK];
    assign w_pc_all  = popcount_chunk(w_ch);
    assign w_pc_lt   = popcount_chunk(w_ch & ~w_ge);
    assign w_hit     = w_ch & w_ge;
    assign w_present = r_valid[r_key];
    assign w_go      = !r_out_valid || !i_out_stall;
    assign w_pos     = !r_used[r_count[SLOT_W-1:0]] ? r_count : first_free(r_used);
    assign o_q_pop   = (r_state == S_IDLE) && i_q_valid;
    assign o_out_valid = r_out_valid;
    assign o_out     = r_out;

    // key-order mask: bits at or above the sought key within this chunk
    always_comb begin
        for (int i = 0; i < SCAN_CHUNK; i++) begin
            w_ge[i] = ({r_chunk, CIDX_W'(i)} >= r_req.key);
        end
    end

    // pick the set bit whose prefix count equals the remaining rank
    always_comb begin
        for (int i = 0; i < SCAN_CHUNK; i++) begin
            w_sel[i] = w_ch[i] &&
                (popcount_chunk(w_ch & ((SCAN_CHUNK'(1) << i) - SCAN_CHUNK'(1)))
                 == r_left[PC_W-1:0]) && (r_left < 6'(SCAN_CHUNK));
        end
    end

    always_comb begin
        n_count  = r_count;
        n_out    = '0;
        w_map_we = 1'b0;
        w_val_we = 1'b0;
        w_val_wa = r_map_q;
        w_val_wd = r_req.value;
        n_out.status = ST_MISS;
        case (r_req.cmd)
            CMD_INSERT: begin
                if (w_present) begin
                    n_out.status = ST_MISS;
                end else if (r_count >= 6'(SLOTS)) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_out.status = ST_OK;
                    w_map_we = 1'b1;
                    w_val_we = 1'b1;
                    w_val_wa = w_pos;
                    n_count  = r_count + 6'd1;
                end
            end
            CMD_REMOVE: begin
                if (w_present) begin
                    n_out.status      = ST_OK;
                    n_out.found_child = r_val_q;
                    n_count           = r_count - 6'd1;
                end
            end
            CMD_CHANGE: begin
                if (w_present) begin
                    n_out.status = ST_OK;
                    w_val_we     = 1'b1;
                end
            end
            CMD_LOOKUP: begin
                if (w_present) begin
                    n_out.status      = ST_OK;
                    n_out.found_child = r_val_q;
                end
            end
            CMD_SELECT, CMD_SEEK: begin
                if (!r_miss) begin
                    n_out.status      = ST_OK;
                    n_out.found_child = r_val_q;
                    n_out.found_key   = r_key;
                    n_out.found_rank  = r_frank;
                end
            end
            default: n_out.status = ST_MISS;
        endcase
        n_out.occupancy    = n_count;
        n_out.is_full      = (n_count == 6'(SLOTS));
        n_out.is_underfull = (n_count == r_under);
    end

    always_ff @(posedge i_clk) begin
        r_map_q <= r_map[r_key];
        if ((r_state == S_EXEC) && w_go && w_map_we) begin
            r_map[r_key] <= w_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val_q <= r_vals[r_map_q];
        if ((r_state == S_EXEC) && w_go && w_val_we) begin
            r_vals[w_val_wa] <= w_val_wd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_used      <= '0;
            r_count     <= '0;
            r_under     <= UNDERFULL_RST;
            r_out_valid <= 1'b0;
            r_miss      <= 1'b0;
            r_chunk     <= '0;
        end else begin
            if (i_cfg_we) begin
                r_under <= i_cfg_wdata;
            end
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_req   <= i_q_req;
                        r_key   <= i_q_req.key;
                        r_left  <= i_q_req.rank;
                        r_frank <= i_q_req.rank;
                        r_chunk <= '0;
                        r_miss  <= 1'b0;
                        case (i_q_req.cmd)
                            CMD_SEEK: begin
                                r_frank <= '0;
                                r_state <= S_SCAN;
                            end
                            CMD_SELECT: begin
                                if (i_q_req.rank < r_count) begin
                                    r_state <= S_SCAN;
                                end else begin
                                    r_miss  <= 1'b1;
                                    r_state <= S_EXEC;
                                end
                            end
                            CMD_BAD: r_state <= S_EXEC;
                            default: r_state <= S_RDMAP;
                        endcase
                    end
                end
                S_SCAN: begin
                    if (r_req.cmd == CMD_SEEK) begin
                        r_frank <= r_frank + 6'(w_pc_lt);
                        if (|w_hit) begin
                            r_key   <= {r_chunk, first_set_chunk(w_hit)};
                            r_state <= S_RDMAP;
                        end else if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                            r_miss  <= 1'b1;
                            r_state <= S_EXEC;
                        end
                    end else begin
                        if (|w_sel) begin
                            r_key   <= {r_chunk, first_set_chunk(w_sel)};
                            r_state <= S_RDMAP;
                        end else begin
                            r_left <= r_left - 6'(w_pc_all);
                            if (r_chunk == CHUNK_W'(CHUNKS - 1)) begin
                                r_miss  <= 1'b1;
                                r_state <= S_EXEC;
                            end
                        end
                    end
                    r_chunk <= r_chunk + CHUNK_W'(1);
                end
                S_RDMAP: r_state <= S_RDVAL;
                S_RDVAL: r_state <= S_EXEC;
                S_EXEC: begin
                    if (w_go) begin
                        r_out       <= n_out;
                        r_out_valid <= 1'b1;
                        r_count     <= n_count;
                        r_state     <= S_IDLE;
                        if (r_req.cmd == CMD_INSERT && n_out.status == ST_OK) begin
                            r_valid[r_key] <= 1'b1;
                            r_used[w_pos]  <= 1'b1;
                        end else if (r_req.cmd == CMD_REMOVE && w_present) begin
                            r_valid[r_key]   <= 1'b0;
                            r_used[r_map_q]  <= 1'b0;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

[rtl/radix_node48_child_table.sv]
// ----------------------------------------------------------------------------
// radix_node48_child_table
// One 48-way radix index node: 256-entry key map and 48-slot child store.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry one request beat (operation,
// key, child value, rank). Output channel: o_out_valid / i_out_stall carry
// one result beat per request, in order.
// Requests go into a 2-deep queue; the executing sequencer takes one at a
// time. Insert, remove, change and lookup pass from queue head to the result
// register through map read, slot read and execute. Rank select and seek scan
// the key occupancy 32 keys per cycle. A bad opcode or an out-of-range rank
// goes straight to execute; the scan over eight chunks makes select and seek
// the longest requests. A finished result waits in the output register while
// the next request is already queued; a stalled result holds and the sequencer
// waits at execute. i_cfg_we writes the underfull level (reset 12); the user
// must write it only while the block is idle; the block does not enforce this.
// Reset (synchronous, active low) empties the node: key valid and slot used
// bits clear at once, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module radix_node48_child_table import rn48_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  t_in        i_in,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_out       o_out,
    input  logic       i_cfg_we,
    input  logic [5:0] i_cfg_wdata
);

    logic q_valid, q_pop;
    t_req q_req;

    rn48_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in       (i_in),
        .o_q_valid  (q_valid),
        .o_q_req    (q_req),
        .i_q_pop    (q_pop)
    );

    rn48_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_valid   (q_valid),
        .i_q_req     (q_req),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out)
    );

endmodule

[rtl/rn48_checker.sv]
// ----------------------------------------------------------------------------
// rn48_checker
// Port-level checks for the node48 child table, bound to the top level.
// ----------------------------------------------------------------------------
module rn48_checker import rn48_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic o_out_valid,
    input logic i_out_stall,
    input t_out o_out
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out))
        else $error("result beat dropped or changed under stall");

    a_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.occupancy <= 6'(SLOTS)) &&
                        (o_out.is_full == (o_out.occupancy == 6'(SLOTS))))
        else $error("occupancy out of range or full flag wrong");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status != ST_OK) |->
            (o_out.found_child == 64'd0) && (o_out.found_key == 8'd0))
        else $error("error result carries data");

    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out.status == ST_FULL) |-> o_out.is_full)
        else $error("full status while not full");

endmodule

bind radix_node48_child_table rn48_checker u_rn48_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out       (o_out)
);

[tb/sv/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the node48 child table: directed and random
// request beats, an in-bench model of key map and slot store, in-order
// comparison of every result beat, underfull level swept between phases.
// ----------------------------------------------------------------------------
module tb_top;
    import rn48_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    t_in        i_in;
    logic       o_out_valid;
    logic       i_out_stall;
    t_out       o_out;
    logic       i_cfg_we;
    logic [5:0] i_cfg_wdata;

    radix_node48_child_table uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // node model
    logic        key_used [KEYS];
    logic [5:0]  key_slot [KEYS];
    logic [63:0] slot_val [SLOTS];
    logic        slot_used [SLOTS];
    int          children;
    logic [5:0]  underfull_lvl;

    t_in  pending_reqs[$];
    t_out expected_results[$];
    int   send_idle_pct;
    int   recv_stall_pct;
    int   mismatches;
    int   beats_sent;
    int   beats_checked;

    function automatic t_out node_apply(input t_in req);
        t_out r;
        int   s;
        int   below;
        int   left;
        r = '0;
        r.status = ST_MISS;
        s = key_slot[req.key_byte] % SLOTS;
        case (req.operation)
            OP_INSERT: begin
                if (key_used[req.key_byte]) begin
                    r.status = ST_MISS;
                end else if (children >= SLOTS) begin
                    r.status = ST_FULL;
                end else begin
                    s = children;
                    if (slot_used[s]) begin
                        for (s = 0; s < SLOTS && slot_used[s]; s++) ;
                    end
                    slot_val[s] = req.child_value;
                    slot_used[s] = 1'b1;
                    key_slot[req.key_byte] = 6'(s);
                    key_used[req.key_byte] = 1'b1;
                    children++;
                    r.status = ST_OK;
                end
            end
            OP_REMOVE: begin
                if (key_used[req.key_byte]) begin
                    r.found_child = slot_val[s];
                    slot_val[s] = '0;
                    slot_used[s] = 1'b0;
                    key_used[req.key_byte] = 1'b0;
                    key_slot[req.key_byte] = '0;
                    if (children > 0) children--;
                    r.status = ST_OK;
                end
            end
            OP_CHANGE: begin
                if (key_used[req.key_byte]) begin
                    slot_val[s] = req.child_value;
                    r.status = ST_OK;
                end
            end
            OP_LOOKUP: begin
                if (key_used[req.key_byte]) begin
                    r.found_child = slot_val[s];
                    r.status = ST_OK;
                end
            end
            OP_SELECT: begin
                if (req.wanted_rank < children) begin
                    left = req.wanted_rank;
                    for (int k = 0; k < KEYS; k++) begin
                        if (key_used[k]) begin
                            if (left == 0 && r.status != ST_OK) begin
                                r.found_key = 8'(k);
                                r.found_child = slot_val[key_slot[k] % SLOTS];
                                r.found_rank = req.wanted_rank;
                                r.status = ST_OK;
                            end
                            left--;
                        end
                    end
                end
            end
            OP_SEEK: begin
                below = 0;
                for (int k = 0; k < KEYS; k++) begin
                    if (key_used[k] && r.status != ST_OK) begin
                        if (k >= req.key_byte) begin
                            r.found_key = 8'(k);
                            r.found_child = slot_val[key_slot[k] % SLOTS];
                            r.found_rank = 6'(below);
                            r.status = ST_OK;
                        end else begin
                            below++;
                        end
                    end
                end
            end
            default: ;
        endcase
        r.occupancy = 6'(children);
        r.is_full = (children == SLOTS);
        r.is_underfull = (children == underfull_lvl);
        return r;
    endfunction

    function automatic t_in make_req(input logic [2:0] op, input logic [7:0] key,
                                     input logic [63:0] val, input logic [5:0] rank);
        t_in q;
        q.operation = op;
        q.key_byte = key;
        q.child_value = val;
        q.wanted_rank = rank;
        return q;
    endfunction

    function automatic logic [63:0] rand_value();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    // keys bunched in a narrow window most of the time so hits are common
    function automatic logic [7:0] rand_key(input int base);
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        return 8'(base + $urandom_range(0, 63));
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("tb_top: done, errors");
        $finish;
    end

    // driver; the model is advanced at the edge the beat goes onto the wire
    always @(posedge i_clk) begin
        t_in nxt;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            i_in <= '0;
        end else if (!(i_in_valid && o_in_stall)) begin
            if (pending_reqs.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                nxt = pending_reqs.pop_front();
                i_in <= nxt;
                i_in_valid <= 1'b1;
                expected_results.push_back(node_apply(nxt));
                beats_sent++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            beats_checked++;
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result beat %p", o_out);
            end else begin
                want = expected_results.pop_front();
                if (want !== o_out) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch beat %0d", beats_checked);
                        $display("  exp st=%0d child=%h key=%0d rank=%0d occ=%0d f=%0d u=%0d",
                                 want.status, want.found_child, want.found_key,
                                 want.found_rank, want.occupancy, want.is_full,
                                 want.is_underfull);
                        $display("  got st=%0d child=%h key=%0d rank=%0d occ=%0d f=%0d u=%0d",
                                 o_out.status, o_out.found_child, o_out.found_key,
                                 o_out.found_rank, o_out.occupancy, o_out.is_full,
                                 o_out.is_underfull);
                    end
                end
            end
        end
    end

    task automatic drain();
        while (pending_reqs.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_level(input logic [5:0] lvl);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= lvl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        underfull_lvl = lvl;
    endtask

    task automatic random_phase(input int n);
        int base;
        int op;
        base = $urandom_range(0, 192);
        for (int k = 0; k < n; k++) begin
            op = $urandom_range(0, 99);
            if (op < 30)
                op = OP_INSERT;
            else if (op < 45)
                op = OP_REMOVE;
            else if (op < 55)
                op = OP_CHANGE;
            else if (op < 67)
                op = OP_LOOKUP;
            else if (op < 80)
                op = OP_SELECT;
            else if (op < 95)
                op = OP_SEEK;
            else
                op = $urandom_range(6, 7);
            pending_reqs.push_back(make_req(3'(op), rand_key(base), rand_value(),
                                            6'($urandom_range(0, 63))));
        end
    endtask

    initial begin
        for (int k = 0; k < KEYS; k++) begin
            key_used[k] = 1'b0;
            key_slot[k] = '0;
        end
        for (int s = 0; s < SLOTS; s++) begin
            slot_val[s] = '0;
            slot_used[s] = 1'b0;
        end
        children = 0;
        underfull_lvl = UNDERFULL_RST;
        mismatches = 0;
        beats_sent = 0;
        beats_checked = 0;
        send_idle_pct = 12;
        recv_stall_pct = 81;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_level(6'd0);

        // directed: empty node misses, extremes, bad opcodes
        pending_reqs.push_back(make_req(OP_LOOKUP, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(OP_SEEK, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(OP_SELECT, 8'd0, '0, 6'd0));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd255, '0, '0));
        pending_reqs.push_back(make_req(OP_CHANGE, 8'd7, '1, '0));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd255, '1, 6'd63));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd255, 64'h5, '0));
        pending_reqs.push_back(make_req(OP_SEEK, 8'd1, '0, '0));
        pending_reqs.push_back(make_req(OP_SEEK, 8'd255, '0, '0));
        pending_reqs.push_back(make_req(OP_SELECT, 8'd0, '0, 6'd1));
        pending_reqs.push_back(make_req(OP_SELECT, 8'd0, '0, 6'd2));
        pending_reqs.push_back(make_req(OP_SELECT, 8'd0, '0, 6'd63));
        pending_reqs.push_back(make_req(OP_CHANGE, 8'd0, 64'hA5A5_5A5A_0F0F_F0F0, '0));
        pending_reqs.push_back(make_req(OP_LOOKUP, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(3'd6, 8'd0, '1, '1));
        pending_reqs.push_back(make_req(3'd7, 8'd255, '1, '1));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd0, '0, '0));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd255, '0, '0));
        drain();
        write_level(6'd48);

        // fill to full, overflow, slot reuse out of order, empty again
        for (int k = 0; k < SLOTS; k++)
            pending_reqs.push_back(make_req(OP_INSERT, 8'(k * 5), rand_value(), '0));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd1, '1, '0));
        pending_reqs.push_back(make_req(OP_SELECT, 8'd0, '0, 6'd47));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd10, '0, '0));
        pending_reqs.push_back(make_req(OP_REMOVE, 8'd200, '0, '0));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd3, '1, '0));
        pending_reqs.push_back(make_req(OP_INSERT, 8'd4, 64'h1, '0));
        for (int k = 0; k < 256; k++)
            pending_reqs.push_back(make_req(OP_REMOVE, 8'(k), '0, '0));
        drain();

        for (int ph = 0; ph < 3; ph++) begin
            send_idle_pct = (ph == 0) ? 12 : (ph == 1) ? 81 : 0;
            recv_stall_pct = (ph == 0) ? 81 : (ph == 1) ? 12 : 0;
            write_level(6'($urandom_range(0, 20)));
            random_phase(120);
            drain();
            // second batch of the phase, sent once all earlier results are back
            random_phase(120);
            drain();
        end
        $display("covered all ops, bad opcodes, full/empty node, levels 0..48");
        $display("sent %0d request beats, checked %0d result beats",
                 beats_sent, beats_checked);
        if (mismatches == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

endmodule
